>>> src/lru_key_value_cache_assert.svh
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

>>> src/lkv_cache_pkg.sv
// Constants shared by the LRU key/value cache.
`default_nettype none
package lkv_cache_pkg;

  localparam int unsigned KEY_W       = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned DEF_ENTRIES = 16;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(16);
  localparam logic [DATA_W-1:0] MISS_DATA = {DATA_W{1'b1}};

  // Operation codes of an input transfer.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

endpackage
`default_nettype wire

>>> src/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
`default_nettype none
// Fully associative key/value cache of ENTRIES entries with least-recently-used
// replacement. Keys, values and per-entry {valid, rank} metadata sit in
// memories with one read and one write port, and a single key comparator
// walks them one entry per cycle. A read transfer is one scan pass plus a
// response and returns one result; a write transfer is a lookup pass, a
// metadata update pass that ages, evicts and inserts, and a final key/value
// write, and returns nothing. The block takes one item at a time. After reset
// a clearing pass zeroes the metadata memory before the first item is
// accepted; capacity writes are taken at any time. A capacity of zero acts as
// one and a capacity above ENTRIES acts as ENTRIES.
module lru_key_value_cache
  import lkv_cache_pkg::*;
#(
  parameter int unsigned ENTRIES = DEF_ENTRIES
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_operation,
  input  wire logic signed [KEY_W-1:0]  in_key,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          out_hit,
  output logic signed [DATA_W-1:0]      out_read_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CAP_W-1:0]         cfg_capacity
);

  `include "lru_key_value_cache_assert.svh"

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned MW   = IW + 1;

  localparam logic [CW-1:0]   ENT_CW   = CW'(ENTRIES);
  localparam logic [CW-1:0]   LAST_CW  = CW'(ENTRIES - 1);
  localparam logic [CMPW-1:0] ENT_CMP  = CMPW'(ENTRIES);
  localparam logic [CMPW-1:0] ONE_CMP  = CMPW'(1);

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_UPDATE = 6'b001000,
    S_FINISH = 6'b010000,
    S_RESP   = 6'b100000
  } state_t;

  // Storage.
  logic [KEY_W-1:0]  key_mem  [ENTRIES];
  logic [DATA_W-1:0] val_mem  [ENTRIES];
  logic [MW-1:0]     meta_mem [ENTRIES];

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pv_r, pv_nxt;
  logic [IW-1:0]     pidx_r, pidx_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic [CW-1:0]     occ_r, occ_nxt;

  logic              op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;

  logic              hit_r, hit_nxt;
  logic [IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]     hit_rank_r, hit_rank_nxt;
  logic [DATA_W-1:0] hit_val_r, hit_val_nxt;
  logic              free_found_r, free_found_nxt;
  logic [IW-1:0]     free_idx_r, free_idx_nxt;
  logic              lru_found_r, lru_found_nxt;
  logic [IW-1:0]     lru_idx_r, lru_idx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r;
  logic [DATA_W-1:0] out_data_r;

  logic [KEY_W-1:0]  key_q;
  logic [DATA_W-1:0] val_q;
  logic [MW-1:0]     meta_q;

  logic              issue;
  logic              pass_done;
  logic [IW-1:0]     raddr;
  logic              meta_we;
  logic [IW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata;
  logic              kv_we;
  logic [IW-1:0]     tgt_idx;
  logic [CMPW-1:0]   cap_eff;
  logic              in_xfer;
  logic              resp_load;

  logic              m_valid;
  logic [IW-1:0]     m_rank;
  logic [CMPW-1:0]   m_rank_inc;
  logic              m_evict;
  logic [CMPW-1:0]   occ_cmp;
  logic [CMPW-1:0]   occ_ins;

  assign in_ready      = (state_r == S_IDLE);
  assign in_xfer       = in_valid & in_ready;
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_hit       = out_hit_r;
  assign out_read_data = out_data_r;

  // Effective capacity: zero acts as one, values above the depth saturate.
  always_comb begin
    cap_eff = CMPW'(cap_r);
    if (cap_r == '0) begin
      cap_eff = ONE_CMP;
    end else if (cap_eff > ENT_CMP) begin
      cap_eff = ENT_CMP;
    end
  end

  // Scan sequencing: one address issued per cycle, read data registered the cycle after.
  assign issue     = (cnt_r != ENT_CW);
  assign pass_done = !issue && !pv_r;
  assign raddr     = cnt_r[IW-1:0];

  // Fields of the entry whose metadata just came out of memory.
  assign m_valid    = meta_q[IW];
  assign m_rank     = meta_q[IW-1:0];
  assign m_rank_inc = CMPW'(m_rank) + ONE_CMP;
  assign m_evict    = m_valid && (m_rank_inc >= cap_eff);

  // Slot that receives the key and value of a write.
  assign tgt_idx = hit_r ? hit_idx_r : (free_found_r ? free_idx_r : lru_idx_r);

  // Occupancy after inserting a new key, evictions included.
  assign occ_cmp = CMPW'(occ_r);
  assign occ_ins = ((occ_cmp >= cap_eff) ? (cap_eff - ONE_CMP) : occ_cmp) + ONE_CMP;

  // Metadata write port: clearing pass or the aging/eviction/insert pass.
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = pidx_r;
    meta_wdata = meta_q;
    if (state_r == S_CLEAR) begin
      meta_we    = 1'b1;
      meta_waddr = cnt_r[IW-1:0];
      meta_wdata = '0;
    end else if ((state_r == S_UPDATE) && pv_r) begin
      meta_we = 1'b1;
      if (hit_r) begin
        if (pidx_r == hit_idx_r) begin
          meta_wdata = {1'b1, {IW{1'b0}}};
        end else if (m_valid && (m_rank < hit_rank_r)) begin
          meta_wdata = {1'b1, m_rank_inc[IW-1:0]};
        end
      end else begin
        if (pidx_r == tgt_idx) begin
          meta_wdata = {1'b1, {IW{1'b0}}};
        end else if (m_evict) begin
          meta_wdata = '0;
        end else if (m_valid) begin
          meta_wdata = {1'b1, m_rank_inc[IW-1:0]};
        end
      end
    end
  end

  assign kv_we     = (state_r == S_FINISH);
  assign resp_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // Sequencer and scan bookkeeping.
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pv_nxt         = 1'b0;
    pidx_nxt       = pidx_r;
    occ_nxt        = occ_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_rank_nxt   = hit_rank_r;
    hit_val_nxt    = hit_val_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    lru_found_nxt  = lru_found_r;
    lru_idx_nxt    = lru_idx_r;
    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == LAST_CW) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt      = S_SCAN;
          cnt_nxt        = '0;
          hit_nxt        = 1'b0;
          free_found_nxt = 1'b0;
          lru_found_nxt  = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        pv_nxt   = issue;
        pidx_nxt = raddr;
        // Compare the entry read in the previous cycle.
        if (pv_r) begin
          if (m_valid && (key_q == key_r)) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = pidx_r;
            hit_rank_nxt = m_rank;
            hit_val_nxt  = val_q;
          end
          if (!m_valid && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = pidx_r;
          end
          if (m_valid && (CW'(m_rank) + CW'(1) == occ_r)) begin
            lru_found_nxt = 1'b1;
            lru_idx_nxt   = pidx_r;
          end
        end
        if (pass_done) begin
          cnt_nxt   = '0;
          pv_nxt    = 1'b0;
          state_nxt = (op_r == OP_WRITE) ? S_UPDATE : S_RESP;
        end
      end
      S_UPDATE: begin
        if (issue) begin
          cnt_nxt = cnt_r + CW'(1);
        end
        pv_nxt   = issue;
        pidx_nxt = raddr;
        if (pass_done) begin
          pv_nxt    = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!hit_r) begin
          occ_nxt = occ_ins[CW-1:0];
        end
        state_nxt = S_IDLE;
      end
      S_RESP: begin
        if (resp_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register: a finished lookup waits here until transferred.
  always_comb begin
    out_valid_nxt = out_valid_r & ~out_ready;
    if (resp_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      pv_r         <= 1'b0;
      occ_r        <= '0;
      cap_r        <= CAP_RESET;
      out_valid_r  <= 1'b0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      lru_found_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      pv_r         <= pv_nxt;
      occ_r        <= occ_nxt;
      out_valid_r  <= out_valid_nxt;
      hit_r        <= hit_nxt;
      free_found_r <= free_found_nxt;
      lru_found_r  <= lru_found_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_rank_r <= hit_rank_nxt;
    hit_val_r  <= hit_val_nxt;
    free_idx_r <= free_idx_nxt;
    lru_idx_r  <= lru_idx_nxt;
    if (in_xfer) begin
      op_r    <= in_operation;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (resp_load) begin
      out_hit_r  <= hit_r;
      out_data_r <= hit_r ? hit_val_r : MISS_DATA;
    end
  end

  // Memories: registered reads at the scan address, one write port each.
  always_ff @(posedge clk) begin
    key_q  <= key_mem[raddr];
    val_q  <= val_mem[raddr];
    meta_q <= meta_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (kv_we) begin
      key_mem[tgt_idx] <= key_r;
      val_mem[tgt_idx] <= value_r;
    end
  end

  // Checks on the sequencer.
  `LKV_ASSERT_NOW(a_occ_bound, 1'b1, occ_r <= ENT_CW)
  `LKV_ASSERT_NOW(a_insert_slot, (state_r == S_FINISH) && !hit_r,
                  free_found_r || lru_found_r)
  `LKV_ASSERT_NOW(a_no_meta_write_in_scan, state_r == S_SCAN, !meta_we)
  `LKV_ASSERT_NEXT(a_insert_occupied, (state_r == S_FINISH) && !hit_r, occ_r != '0)

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the LRU key/value cache: directed table, random traffic, checker.
`timescale 1ns / 100ps

module tb_top;
  import lkv_cache_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 2 * DEF_ENTRIES + 16;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 170;
  localparam int unsigned POOL_MAX      = 24;
  localparam int unsigned LOG_CAP       = 100;

  // Kinds of rows in the directed table.
  typedef enum logic [1:0] {ROW_READ, ROW_WRITE, ROW_CAP} row_kind_e;

  // Receiver back-pressure patterns.
  typedef enum logic [1:0] {RDY_OPEN, RDY_COIN, RDY_SPARSE} ready_mode_e;

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
  } lookup_result_t;

  // One directed row: arg is the value of a write or the capacity of a register write.
  typedef struct packed {
    row_kind_e         kind;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] arg;
    logic              fixed_exp;
    logic              hit;
    logic [DATA_W-1:0] data;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 25;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ROW_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{ROW_READ,  32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{ROW_WRITE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{ROW_WRITE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{ROW_WRITE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_CAP,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, 32'h0000_0005, 32'h0000_0055, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h8000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{ROW_READ,  32'h0000_0005, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, 32'h0000_0006, 32'h0000_0066, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h0000_0005, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{ROW_READ,  32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_CAP,   32'h0000_0000, 32'h0000_001F, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, 32'h0000_0007, 32'h0000_0077, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h0000_0006, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{ROW_CAP,   32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{ROW_WRITE, 32'h0000_0008, 32'h0000_0088, 1'b0, 1'b0, 32'h0},
    '{ROW_READ,  32'h0000_0007, 32'h0000_0000, 1'b1, 1'b0, MISS_DATA},
    '{ROW_READ,  32'h0000_0008, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
  };

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_operation  = OP_READ;
  logic [KEY_W-1:0]  in_key        = '0;
  logic [DATA_W-1:0] in_value      = '0;
  logic              out_ready     = 1'b0;
  logic              cfg_valid     = 1'b0;
  logic [CAP_W-1:0]  cfg_capacity  = CAP_RESET;
  logic              in_ready;
  logic              out_valid;
  logic              out_hit;
  logic [DATA_W-1:0] out_read_data;
  logic              cfg_ready;

  lru_key_value_cache dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_read_data (out_read_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_capacity  (cfg_capacity)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow copy of the cache contents and its capacity register.
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  logic [KEY_W-1:0]  line_key  [DEF_ENTRIES];
  logic [DATA_W-1:0] line_data [DEF_ENTRIES];
  bit                line_live [DEF_ENTRIES];
  int unsigned       line_age  [DEF_ENTRIES];
  int unsigned       lines_used = 0;

  lookup_result_t pending_lookups [$];

  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned reads_sent   = 0;
  int unsigned writes_sent  = 0;
  int unsigned cap_writes   = 0;
  int unsigned hits_seen    = 0;
  int unsigned misses_seen  = 0;
  int unsigned evictions    = 0;
  int unsigned burst_left   = 0;

  // Capacity zero acts as one; anything above the entry count saturates.
  function automatic int unsigned active_capacity();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > DEF_ENTRIES) c = DEF_ENTRIES;
    return c;
  endfunction

  function automatic int find_line(input logic [KEY_W-1:0] k);
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (line_live[i] && line_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic lookup_result_t cache_lookup(input logic [KEY_W-1:0] k);
    lookup_result_t r;
    int slot;
    slot = find_line(k);
    if (slot >= 0) begin
      r.hit  = 1'b1;
      r.data = line_data[slot];
    end else begin
      r.hit  = 1'b0;
      r.data = MISS_DATA;
    end
    return r;
  endfunction

  // Update the shadow copy for one write transfer.
  function automatic void cache_store(input logic [KEY_W-1:0] k, input logic [DATA_W-1:0] v);
    int slot;
    int victim;
    int unsigned old_age;
    int unsigned worst;
    slot = find_line(k);
    if (slot >= 0) begin
      // Present key: entries more recent than it age by one, it becomes most recent.
      old_age = line_age[slot];
      for (int i = 0; i < DEF_ENTRIES; i++) begin
        if (line_live[i] && line_age[i] < old_age) line_age[i]++;
      end
      line_age[slot]  = 0;
      line_data[slot] = v;
      return;
    end
    // New key: evict least recent entries until there is room under the capacity.
    while (lines_used >= active_capacity() && lines_used > 0) begin
      victim = -1;
      worst  = 0;
      for (int i = 0; i < DEF_ENTRIES; i++) begin
        if (line_live[i] && (victim < 0 || line_age[i] >= worst)) begin
          victim = i;
          worst  = line_age[i];
        end
      end
      if (victim < 0) break;
      line_live[victim] = 1'b0;
      line_age[victim]  = 0;
      lines_used--;
      evictions++;
    end
    slot = -1;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (!line_live[i] && slot < 0) slot = i;
    end
    if (slot < 0) return;
    for (int i = 0; i < DEF_ENTRIES; i++) begin
      if (line_live[i]) line_age[i]++;
    end
    line_key[slot]  = k;
    line_data[slot] = v;
    line_live[slot] = 1'b1;
    line_age[slot]  = 0;
    lines_used++;
  endfunction

  // Offer one item, with a random gap at the start of each burst, and predict on transfer.
  task automatic drive_item(input logic op, input logic [KEY_W-1:0] k,
                            input logic [DATA_W-1:0] v, input bit fixed_exp,
                            input lookup_result_t fixed_res);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_operation <= op;
    in_key       <= k;
    in_value     <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op == OP_WRITE) begin
      cache_store(k, v);
      writes_sent++;
    end else begin
      pending_lookups.push_back(fixed_exp ? fixed_res : cache_lookup(k));
      reads_sent++;
    end
  endtask

  // Stop sending, let every expected result arrive, then let a pending write finish.
  task automatic drain_cache();
    in_valid   <= 1'b0;
    burst_left = 0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    cfg_valid    <= 1'b1;
    cfg_capacity <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = c;
    cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: alternates between always ready, coin-flip stalls and long stalls.
  ready_mode_e ready_mode = RDY_OPEN;
  int unsigned ready_span = 0;

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 2));
      ready_span <= $urandom_range(4, 60);
      out_ready  <= 1'b1;
    end else begin
      ready_span <= ready_span - 1;
      case (ready_mode)
        RDY_OPEN: out_ready <= 1'b1;
        RDY_COIN: out_ready <= 1'($urandom_range(0, 1));
        default:  out_ready <= (ready_span % 20 == 0);
      endcase
    end
  end

  // Compare every result transfer with the oldest expected lookup.
  always @(posedge clk) begin : check_results
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        fail_count++;
        if (fail_count <= LOG_CAP)
          $display("%0t: unexpected result: hit %0b data %08h", $time, out_hit, out_read_data);
      end else begin
        want = pending_lookups.pop_front();
        if (out_hit !== want.hit) begin
          fail_count++;
          if (fail_count <= LOG_CAP)
            $display("%0t: hit mismatch: expected %0b actual %0b", $time, want.hit, out_hit);
        end
        if (out_read_data !== want.data) begin
          fail_count++;
          if (fail_count <= LOG_CAP)
            $display("%0t: read_data mismatch: expected %08h actual %08h",
                     $time, want.data, out_read_data);
        end
        if (want.hit) hits_seen++;
        else misses_seen++;
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lru_key_value_cache");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t        row;
    lookup_result_t   fixed_res;
    logic [KEY_W-1:0] key_pool [POOL_MAX];
    logic [KEY_W-1:0] k;
    logic [DATA_W-1:0] v;
    logic             op;
    int unsigned      phase_cap [PHASES];
    int unsigned      pool_size;
    int unsigned      pick;

    for (int i = 0; i < DEF_ENTRIES; i++) begin
      line_key[i]  = '0;
      line_data[i] = '0;
      line_live[i] = 1'b0;
      line_age[i]  = 0;
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: empty cache, extreme keys and values, capacity corner cases.
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = DIRECTED[r];
      fixed_res.hit  = row.hit;
      fixed_res.data = row.data;
      case (row.kind)
        ROW_CAP: begin
          drain_cache();
          write_capacity(row.arg[CAP_W-1:0]);
        end
        ROW_WRITE: drive_item(OP_WRITE, row.key, row.arg, 1'b0, fixed_res);
        default:   drive_item(OP_READ, row.key, $urandom(), row.fixed_exp, fixed_res);
      endcase
    end

    // Random phases: fill at full size, saturate, shrink below occupancy, the extremes.
    phase_cap = '{16, 31, 3, 1, 0, 0, 0, 16};
    phase_cap[5] = $urandom_range(2, 15);
    phase_cap[6] = $urandom_range(0, 31);
    for (int p = 0; p < PHASES; p++) begin
      drain_cache();
      write_capacity(phase_cap[p][CAP_W-1:0]);

      // A small key pool per phase so that reads hit and writes revisit keys.
      pool_size = active_capacity() + $urandom_range(1, 8);
      for (int i = 0; i < POOL_MAX; i++) begin
        case ($urandom_range(0, 9))
          0:       key_pool[i] = 32'h8000_0000;
          1:       key_pool[i] = 32'h7FFF_FFFF;
          2:       key_pool[i] = 32'hFFFF_FFFF;
          3:       key_pool[i] = 32'h0000_0000;
          default: key_pool[i] = $urandom();
        endcase
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op   = ($urandom_range(0, 99) < 50) ? OP_WRITE : OP_READ;
        pick = $urandom_range(0, 99);
        k    = (pick < 85) ? key_pool[$urandom_range(0, pool_size - 1)] : $urandom();
        case ($urandom_range(0, 19))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7FFF_FFFF;
          2:       v = 32'hFFFF_FFFF;
          default: v = $urandom();
        endcase
        drive_item(op, k, v, 1'b0, '0);
        // Now and then hold off until every outstanding lookup has come back.
        if ($urandom_range(0, 79) == 0) drain_cache();
      end
    end

    drain_cache();

    $display("Covered %0d writes and %0d reads (%0d hits, %0d misses), %0d evictions,",
             writes_sent, reads_sent, hits_seen, misses_seen, evictions);
    $display("over %0d capacity writes including zero, one, sixteen and thirty-one.",
             cap_writes);
    if (fail_count == 0) begin
      $display("PASS lru_key_value_cache");
    end else begin
      $display("FAIL lru_key_value_cache");
    end
    $finish;
  end

endmodule
